// ===== hdl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W        = 21;
    localparam int FIFO_DEPTH  = 2;
    localparam int RES_CNT_W   = 2;

    localparam logic [CP_W-1:0] REPL_CHAR   = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT  = 8'hF5;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    // One input item
    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_text;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [CP_W-1:0] cp_value;
        logic            was_replaced;
        logic            last_of_item;
        logic            text_done;
    } out_item_t;

    // Results caused by one byte, in order
    typedef struct packed {
        out_item_t             first;
        out_item_t             second;
        logic [RES_CNT_W-1:0]  count;
    } res_pair_t;

endpackage

// ===== hdl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  in_item,
    input  logic      consume,
    output res_pair_t res
);

    logic [CP_W-1:0] partial_value_reg, partial_value_next;
    logic [1:0]      bytes_remaining_reg, bytes_remaining_next;
    logic [1:0]      sequence_length_reg, sequence_length_next;

    // Decode of the current byte against the open sequence
    always_comb begin
        logic [7:0]      b;
        logic            eot;
        logic            is_cont;
        logic [CP_W-1:0] v;
        logic            bad;
        logic            lead_emit;
        logic            lead_start;
        out_item_t       lead_item;
        logic [CP_W-1:0] lead_val;
        logic [1:0]      lead_cont;
        out_item_t       repl_item;

        b       = in_item.byte_value;
        eot     = in_item.end_of_text;
        is_cont = (b & CONT_MASK) == CONT_TAG;
        v       = {partial_value_reg[CP_W-7:0], b[5:0]};

        repl_item = '{cp_value: REPL_CHAR, was_replaced: 1'b1,
                      last_of_item: 1'b0, text_done: 1'b0};

        // Lead byte classification
        lead_start = 1'b0;
        lead_emit  = 1'b1;
        lead_val   = '0;
        lead_cont  = 2'd0;
        lead_item  = repl_item;
        if (b < ASCII_LIMIT) begin
            lead_item = '{cp_value: {13'd0, b}, was_replaced: 1'b0,
                          last_of_item: 1'b0, text_done: 1'b0};
        end else if (b < LEAD2_MIN || b >= LEAD_LIMIT) begin
            lead_item = repl_item;
        end else begin
            lead_start = 1'b1;
            lead_emit  = eot;
            if (b < LEAD3_MIN) begin
                lead_val  = {16'd0, b[4:0]};
                lead_cont = 2'd1;
            end else if (b < LEAD4_MIN) begin
                lead_val  = {17'd0, b[3:0]};
                lead_cont = 2'd2;
            end else begin
                lead_val  = {18'd0, b[2:0]};
                lead_cont = 2'd3;
            end
        end

        // Completed sequence checks
        bad = (sequence_length_reg == 2'd1 && v < MIN_2BYTE) ||
              (sequence_length_reg == 2'd2 && v < MIN_3BYTE) ||
              (sequence_length_reg == 2'd3 && v < MIN_4BYTE) ||
              (v >= SURR_LO && v <= SURR_HI) ||
              (v > MAX_SCALAR);

        res                  = '0;
        partial_value_next   = '0;
        bytes_remaining_next = '0;
        sequence_length_next = '0;

        if (bytes_remaining_reg != 2'd0 && is_cont) begin
            // Continuation of an open sequence
            if (bytes_remaining_reg == 2'd1) begin
                res.first = '{cp_value: bad ? REPL_CHAR : v, was_replaced: bad,
                              last_of_item: 1'b0, text_done: 1'b0};
                res.count = 2'd1;
            end else if (eot) begin
                res.first = repl_item;
                res.count = 2'd1;
            end else begin
                partial_value_next   = v;
                bytes_remaining_next = bytes_remaining_reg - 2'd1;
                sequence_length_next = sequence_length_reg;
            end
        end else begin
            // Broken sequence first, then the byte as a lead
            if (bytes_remaining_reg != 2'd0) begin
                res.first = repl_item;
                if (lead_emit) begin
                    res.second = lead_item;
                    res.count  = 2'd2;
                end else begin
                    res.count  = 2'd1;
                end
            end else if (lead_emit) begin
                res.first = lead_item;
                res.count = 2'd1;
            end
            if (lead_start && !eot) begin
                partial_value_next   = lead_val;
                bytes_remaining_next = lead_cont;
                sequence_length_next = lead_cont;
            end
        end

        // Mark the final result of this byte
        if (res.count == 2'd1) begin
            res.first.last_of_item = 1'b1;
            res.first.text_done    = eot;
        end else if (res.count == 2'd2) begin
            res.second.last_of_item = 1'b1;
            res.second.text_done    = eot;
        end
    end

    // Sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_value_reg   <= '0;
            bytes_remaining_reg <= '0;
            sequence_length_reg <= '0;
        end else if (consume) begin
            partial_value_reg   <= partial_value_next;
            bytes_remaining_reg <= bytes_remaining_next;
            sequence_length_reg <= sequence_length_next;
        end
    end

    a_len_covers_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_remaining_reg != 2'd0 |->
            sequence_length_reg != 2'd0 && bytes_remaining_reg <= sequence_length_reg)
        else $error("open sequence without a matching length");

    a_eot_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_item.end_of_text |=>
            bytes_remaining_reg == 2'd0 && partial_value_reg == '0)
        else $error("state not cleared at end of text");

    a_eot_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_item.end_of_text |-> res.count != 2'd0)
        else $error("end of text without a result");

    a_two_means_broken: assert property (@(posedge aclk) disable iff (!aresetn)
        res.count == 2'd2 |-> res.first.was_replaced && bytes_remaining_reg != 2'd0)
        else $error("two results without a broken sequence");

endmodule

// ===== hdl/utf8d_out_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_fifo
// Two-entry result register; takes up to two items per cycle, gives one.
// ----------------------------------------------------------------------------
module utf8d_out_fifo
    import utf8d_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  res_pair_t            push_data,
    output logic [RES_CNT_W-1:0] free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    out_item_t            slot0_reg, slot0_next;
    out_item_t            slot1_reg, slot1_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic                 pop;
    logic [RES_CNT_W-1:0] keep;

    assign m_valid = count_reg != '0;
    assign m_data  = slot0_reg;
    assign pop     = m_valid && m_ready;
    assign keep    = count_reg - {{(RES_CNT_W-1){1'b0}}, pop};
    assign free    = RES_CNT_W'(FIFO_DEPTH) - keep;

    // Shift out the head, append new items behind what is kept
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (keep == 2'd0) begin
            slot0_next = push_data.first;
            slot1_next = push_data.second;
        end else if (keep == 2'd1) begin
            slot0_next = pop ? slot1_reg : slot0_reg;
            slot1_next = push_data.first;
        end
        count_next = keep + (push ? push_data.count : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= RES_CNT_W'(FIFO_DEPTH))
        else $error("result register overfilled");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> push_data.count <= free)
        else $error("push larger than free space");

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// Path: a byte accepted into the input register is decoded combinationally, and
// its results enter the result register when it advances; that register drives m_valid.
// Throughput: one byte per cycle; a byte with two results is absorbed by the
// two-entry result register, and the input stalls only while results back up.
// Reset (aresetn low, synchronous) empties the input and result registers and
// clears the open sequence.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code points with U+FFFD replacement of bad input.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic                 in_valid_reg;
    in_item_t             in_item_reg;
    res_pair_t            res;
    logic [RES_CNT_W-1:0] free;
    logic                 consume;

    // Input register advances when its item fits into the result register
    assign consume = in_valid_reg && (res.count <= free);
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    utf8d_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_item (in_item_reg),
        .consume (consume),
        .res     (res)
    );

    utf8d_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (consume),
        .push_data (res),
        .free      (free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== sim/utf8_stream_checker.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Watches both channels of the UTF-8 stream decoder, keeps its own decode of
// every accepted byte and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module utf8_stream_checker
    import utf8d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending_results
);

    // Decoder state as the predictor sees it
    logic [CP_W-1:0] acc_value;
    logic [1:0]      cont_left;
    logic [1:0]      cont_total;

    // Results of the byte being decoded, then the queue of expected code points
    out_item_t       byte_res [0:1];
    int              n_res;
    out_item_t       cp_expect_q [$];
    out_item_t       got;
    out_item_t       want;

    task automatic add_result(input logic [CP_W-1:0] cp, input logic repl);
        byte_res[n_res].cp_value     = cp;
        byte_res[n_res].was_replaced = repl;
        byte_res[n_res].last_of_item = 1'b0;
        byte_res[n_res].text_done    = 1'b0;
        n_res = n_res + 1;
    endtask

    task automatic clear_sequence();
        acc_value  = '0;
        cont_left  = 2'd0;
        cont_total = 2'd0;
    endtask

    // A byte seen outside any open sequence
    task automatic decode_lead(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] payload;
        logic [1:0]      conts;
        if (b < ASCII_LIMIT) begin
            add_result({13'd0, b}, 1'b0);
        end else if (b < LEAD2_MIN || b >= LEAD_LIMIT) begin
            add_result(REPL_CHAR, 1'b1);
        end else begin
            if (b < LEAD3_MIN) begin
                payload = {16'd0, b[4:0]};
                conts   = 2'd1;
            end else if (b < LEAD4_MIN) begin
                payload = {17'd0, b[3:0]};
                conts   = 2'd2;
            end else begin
                payload = {18'd0, b[2:0]};
                conts   = 2'd3;
            end
            if (eot) begin
                // lead flagged as final byte: the sequence can never finish
                clear_sequence();
                add_result(REPL_CHAR, 1'b1);
            end else begin
                acc_value  = payload;
                cont_left  = conts;
                cont_total = conts;
            end
        end
    endtask

    // Decode one accepted byte and queue what it should produce
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] v;
        logic            bad;
        n_res = 0;
        if (cont_left != 2'd0) begin
            if ((b & CONT_MASK) == CONT_TAG) begin
                v = {acc_value[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    bad = (cont_total == 2'd1 && v < MIN_2BYTE) ||
                          (cont_total == 2'd2 && v < MIN_3BYTE) ||
                          (cont_total == 2'd3 && v < MIN_4BYTE) ||
                          (v >= SURR_LO && v <= SURR_HI) ||
                          (v > MAX_SCALAR);
                    add_result(bad ? REPL_CHAR : v, bad);
                    clear_sequence();
                end else if (eot) begin
                    // cut short by the end of the text
                    add_result(REPL_CHAR, 1'b1);
                    clear_sequence();
                end else begin
                    acc_value = v;
                end
            end else begin
                // broken sequence, then the byte starts over as a lead
                add_result(REPL_CHAR, 1'b1);
                clear_sequence();
                decode_lead(b, eot);
            end
        end else begin
            decode_lead(b, eot);
        end
        if (n_res > 0) begin
            byte_res[n_res-1].last_of_item = 1'b1;
            byte_res[n_res-1].text_done    = eot;
        end
        for (int i = 0; i < n_res; i++) begin
            cp_expect_q.insert(cp_expect_q.size(), byte_res[i]);
        end
    endtask

    // Handshakes are taken at the rising edge, before the block updates
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_sequence();
            cp_expect_q.delete();
            fail_count      = 0;
            pending_results = 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data.byte_value, s_data.end_of_text);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (cp_expect_q.size() == 0) begin
                    $error("unexpected result: cp_value %h replaced %b last %b done %b",
                           got.cp_value, got.was_replaced, got.last_of_item,
                           got.text_done);
                    fail_count = fail_count + 1;
                end else begin
                    want = cp_expect_q.pop_front();
                    if (got.cp_value !== want.cp_value) begin
                        $error("cp_value: expected %h, got %h",
                               want.cp_value, got.cp_value);
                        fail_count = fail_count + 1;
                    end
                    if (got.was_replaced !== want.was_replaced) begin
                        $error("was_replaced: expected %b, got %b",
                               want.was_replaced, got.was_replaced);
                        fail_count = fail_count + 1;
                    end
                    if (got.last_of_item !== want.last_of_item) begin
                        $error("last_of_item: expected %b, got %b",
                               want.last_of_item, got.last_of_item);
                        fail_count = fail_count + 1;
                    end
                    if (got.text_done !== want.text_done) begin
                        $error("text_done: expected %b, got %b",
                               want.text_done, got.text_done);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_results = cp_expect_q.size();
        end
    end

endmodule

// ===== sim/tb_utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Feeds the UTF-8 stream decoder a short directed run of edge cases, then
// random texts built mostly from well-formed sequences mixed with overlong,
// surrogate, out-of-range, truncated and stray bytes. Both channels idle at
// random; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
    import utf8d_pkg::*;

    localparam int TOTAL_BYTES  = 950;
    localparam int CYCLE_LIMIT  = 200000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int        fail_count;
    int        pending_results;
    int        cycle_count;
    int        bytes_sent;
    int        text_idx;
    int        sink_stall;
    logic      no_idle;
    logic [7:0] text_q [$];

    utf8_stream_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utf8_stream_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one byte after a random gap, return at the negedge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_data.byte_value  = b;
        s_data.end_of_text = eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent = bytes_sent + 1;
        @(negedge aclk);
    endtask

    // Append one byte to the text being built
    task automatic append_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // Encode v with a fixed length, valid or not
    task automatic encode_len(input int nbytes, input logic [20:0] v);
        if (nbytes == 1) begin
            append_byte({1'b0, v[6:0]});
        end else if (nbytes == 2) begin
            append_byte({3'b110, v[10:6]});
            append_byte({2'b10, v[5:0]});
        end else if (nbytes == 3) begin
            append_byte({4'b1110, v[15:12]});
            append_byte({2'b10, v[11:6]});
            append_byte({2'b10, v[5:0]});
        end else begin
            append_byte({5'b11110, v[20:18]});
            append_byte({2'b10, v[17:12]});
            append_byte({2'b10, v[11:6]});
            append_byte({2'b10, v[5:0]});
        end
    endtask

    // A well-formed scalar value of the given encoded length
    task automatic encode_valid(input int nbytes);
        logic [20:0] cp;
        if (nbytes == 1) begin
            cp = 21'($urandom_range(0, 'h7F));
        end else if (nbytes == 2) begin
            cp = 21'($urandom_range('h80, 'h7FF));
        end else if (nbytes == 3) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= 'hD800 && cp <= 'hDFFF) begin
                cp = cp - 21'h800;
            end
        end else begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
        end
        encode_len(nbytes, cp);
    endtask

    // One random text: mostly good characters, some malformed units
    task automatic build_text();
        int units;
        int pick;
        int n;
        int drop;
        text_q.delete();
        units = $urandom_range(1, 10);
        for (int u = 0; u < units; u++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                encode_valid($urandom_range(1, 4));
            end else if (pick < 68) begin
                // overlong form
                n = $urandom_range(2, 4);
                if (n == 2) encode_len(2, 21'($urandom_range(0, 'h7F)));
                else if (n == 3) encode_len(3, 21'($urandom_range(0, 'h7FF)));
                else encode_len(4, 21'($urandom_range(0, 'hFFFF)));
            end else if (pick < 73) begin
                encode_len(3, 21'($urandom_range('hD800, 'hDFFF)));
            end else if (pick < 78) begin
                encode_len(4, 21'($urandom_range('h110000, 'h1FFFFF)));
            end else if (pick < 88) begin
                // sequence missing its tail
                n = $urandom_range(2, 4);
                encode_valid(n);
                drop = $urandom_range(1, n - 1);
                repeat (drop) void'(text_q.pop_back());
            end else begin
                append_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Result side: random stall before taking each result
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            sink_stall = no_idle ? 0 : $urandom_range(0, 6);
            if (sink_stall != 0) begin
                m_ready = 1'b0;
                repeat (sink_stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        no_idle    = 1'b0;
        bytes_sent = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed edge cases
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);                         // stray continuation
        send_byte(8'hC1, 1'b0);                         // never-valid lead
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0); // smallest 2-byte
        send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0); // above U+10FFFF
        send_byte(8'hC2, 1'b0); send_byte(8'h41, 1'b0); // broken by ASCII
        send_byte(8'hE2, 1'b0); send_byte(8'hF0, 1'b1); // broken by final lead
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1); // cut short by end

        // Random texts
        text_idx = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            no_idle = ($urandom_range(0, 7) == 0);
            build_text();
            for (int i = 0; i < text_q.size(); i++) begin
                send_byte(text_q[i], i == text_q.size() - 1);
            end
            // hold off now and then until the decoder has drained
            if (text_idx % 15 == 14) begin
                s_valid = 1'b0;
                while (pending_results != 0) @(negedge aclk);
            end
            text_idx = text_idx + 1;
        end

        s_valid = 1'b0;
        no_idle = 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/utf8d_pkg.sv
hdl/utf8d_decode.sv
hdl/utf8d_out_fifo.sv
hdl/utf8_stream_decoder.sv
sim/utf8_stream_checker.sv
sim/tb_utf8_stream_decoder.sv
